/* rtl/core/rvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_pkg - shared types and constants for the ray voxel carving block
// Controller states, phases, command and status bundles, register indexes.
// ----------------------------------------------------------------------------
package rvc_pkg;

   localparam int WORD_W  = 32;
   localparam int TIME_W  = 64;
   localparam int REL_W   = 40;
   localparam int BOX_W   = 33;
   localparam int VIDX_W  = 18;
   localparam int CSR_IDX_W = 3;

   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 64;

   // entry point clamps
   localparam logic signed [TIME_W-1:0] REL_LIM  = 64'sd274877906944;   // 2^38
   localparam logic [62:0]              PROD_LIM = 63'h4000000000000000; // 2^62

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z  = 3'd6;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_GO,
      ST_WAIT,
      ST_MERGE,
      ST_BOUND,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      PH_SLAB_N,
      PH_SLAB_F,
      PH_ENT_MUL,
      PH_ENT_DIV,
      PH_ENT_T,
      PH_ENT_DT
   } phase_type;

   typedef struct packed {
      logic      clear_step;
      logic      load;
      logic      rd_issue;
      logic      start;
      logic      capture;
      logic      merge;
      logic      bound;
      logic      walk_step;
      phase_type phase;
      logic [1:0] axis;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic unit_done;
      logic miss;
      logic walk_done;
   } ctrl_sts_type;

endpackage

/* rtl/core/rvc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_mul - iterative unsigned multiplier
// 32 x 64 bit shift-add, one multiplier bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module rvc_mul
   import rvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WORD_W-1:0]   a,
   input  logic [TIME_W-1:0]   b,
   output logic                done,
   output logic [TIME_W+WORD_W-1:0] prod
);

   localparam int CNT_W = $clog2(MUL_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] hi_ff;
   logic [WORD_W-1:0] lo_ff;
   logic [TIME_W-1:0] b_ff;
   logic [TIME_W:0]   sum_in;

   assign sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, b_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hi_ff <= '0;
         lo_ff <= a;
         b_ff  <= b;
      end else if (busy_ff) begin
         hi_ff <= sum_in[TIME_W:1];
         lo_ff <= {sum_in[0], lo_ff[WORD_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

/* rtl/core/rvc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_div - iterative unsigned divider
// 64 / 32 bit restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvc_div
   import rvc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] num,
   input  logic [WORD_W-1:0] den,
   output logic              done,
   output logic [TIME_W-1:0] quo,
   output logic [WORD_W-1:0] rem
);

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] num_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] den_ff;
   logic [WORD_W:0]   trial;
   logic              ge;

   assign trial = {rem_ff, num_ff[TIME_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? WORD_W'(trial - {1'b0, den_ff}) : trial[WORD_W-1:0];
         num_ff <= {num_ff[TIME_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/core/rvc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_ctrl - sequencer for the ray voxel carving block
// Clearing pass, read, slab test, entry setup per axis and the voxel walk.
// ----------------------------------------------------------------------------
module rvc_ctrl
   import rvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_func,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [1:0] axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= PH_SLAB_N;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_GO;
                  phase_in = PH_SLAB_N;
                  axis_in  = AXIS_X;
               end
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_GO:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (sts.unit_done) begin
               unique case (phase_ff)
                  PH_SLAB_N: begin
                     state_in = ST_GO;
                     phase_in = PH_SLAB_F;
                  end
                  PH_SLAB_F: begin
                     if (axis_ff == AXIS_Z) begin
                        state_in = ST_MERGE;
                     end else begin
                        state_in = ST_GO;
                        phase_in = PH_SLAB_N;
                        axis_in  = axis_ff + 1'b1;
                     end
                  end
                  PH_ENT_MUL: begin
                     state_in = ST_GO;
                     phase_in = PH_ENT_DIV;
                  end
                  PH_ENT_DIV: state_in = ST_BOUND;
                  PH_ENT_T: begin
                     state_in = ST_GO;
                     phase_in = PH_ENT_DT;
                  end
                  PH_ENT_DT: begin
                     if (axis_ff == AXIS_Z) begin
                        state_in = ST_WALK;
                     end else begin
                        state_in = ST_GO;
                        phase_in = PH_ENT_MUL;
                        axis_in  = axis_ff + 1'b1;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MERGE: begin
            if (sts.miss) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_GO;
               phase_in = PH_ENT_MUL;
               axis_in  = AXIS_X;
            end
         end
         ST_BOUND: begin
            state_in = ST_GO;
            phase_in = PH_ENT_T;
         end
         ST_WALK: begin
            if (sts.walk_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.phase     = phase_ff;
      cmd.axis      = axis_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_READ:  cmd.rd_issue  = 1'b1;
         ST_GO:    cmd.start     = 1'b1;
         ST_WAIT:  cmd.capture   = sts.unit_done;
         ST_MERGE: cmd.merge     = 1'b1;
         ST_BOUND: cmd.bound     = 1'b1;
         ST_WALK:  cmd.walk_step = 1'b1;
         ST_RESP:  rsp_valid     = 1'b1;
         default:  cmd           = '0;
      endcase
   end

endmodule

/* rtl/core/rvc_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_dpath - datapath for the ray voxel carving block
// Config registers, slab test, entry voxel and times, DDA walk, voxel memory.
// ----------------------------------------------------------------------------
module rvc_dpath
   import rvc_pkg::*;
#(
   parameter int GRID_SIDE = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [WORD_W-1:0]          csr_wdata,
   input  logic                       req_func,
   input  logic signed [WORD_W-1:0]   req_origin_x,
   input  logic signed [WORD_W-1:0]   req_origin_y,
   input  logic signed [WORD_W-1:0]   req_origin_z,
   input  logic signed [WORD_W-1:0]   req_dir_x,
   input  logic signed [WORD_W-1:0]   req_dir_y,
   input  logic signed [WORD_W-1:0]   req_dir_z,
   input  logic signed [WORD_W-1:0]   req_inv_dir_x,
   input  logic signed [WORD_W-1:0]   req_inv_dir_y,
   input  logic signed [WORD_W-1:0]   req_inv_dir_z,
   input  logic [VIDX_W-1:0]          req_voxel_index,
   input  ctrl_cmd_type               cmd,
   output ctrl_sts_type               sts,
   output logic                       rsp_hit,
   output logic [7:0]                 rsp_carved_count,
   output logic                       rsp_step_limit_hit,
   output logic                       rsp_voxel_value
);

   localparam int VW    = $clog2(GRID_SIDE);
   localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(3 * GRID_SIDE + 1);
   localparam int IW    = ((AW > VIDX_W) ? AW : VIDX_W) + 1;
   localparam logic [CW-1:0] STEP_CAP  = CW'(3 * GRID_SIDE);
   localparam logic [VW-1:0] VOX_MAX   = VW'(GRID_SIDE - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(GRID_SIDE);
   localparam logic [AW-1:0] PLANE_STEP = AW'(GRID_SIDE * GRID_SIDE);
   localparam logic [IW-1:0] CELLS_W   = IW'(CELLS);
   localparam logic signed [REL_W:0] QMAX = (REL_W+1)'(GRID_SIDE - 1);
   localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};

   function automatic logic earlier(input logic oka, input logic okb,
                                    input logic [TIME_W-1:0] ta,
                                    input logic [TIME_W-1:0] tb);
      return oka && (!okb || ta < tb);
   endfunction

   function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
      return v[WORD_W-1] ? WORD_W'(~v + 1'b1) : WORD_W'(v);
   endfunction

   // ---- configuration ----
   logic [WORD_W-2:0]         vsize_ff;
   logic signed [BOX_W-1:0]   bmin_ff [3];
   logic signed [BOX_W-1:0]   bmax_ff [3];
   logic signed [BOX_W-1:0]   csr_box;

   assign csr_box = BOX_W'($signed(csr_wdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         vsize_ff <= (WORD_W-1)'(64'd1 << FRAC_BITS);
         for (int i = 0; i < 3; i++) begin
            bmin_ff[i] <= '0;
            bmax_ff[i] <= BOX_W'(64'(GRID_SIDE) << FRAC_BITS);
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOXEL_SIZE: vsize_ff   <= csr_wdata[WORD_W-2:0];
            CSR_BOX_MIN_X:  bmin_ff[0] <= csr_box;
            CSR_BOX_MIN_Y:  bmin_ff[1] <= csr_box;
            CSR_BOX_MIN_Z:  bmin_ff[2] <= csr_box;
            CSR_BOX_MAX_X:  bmax_ff[0] <= csr_box;
            CSR_BOX_MAX_Y:  bmax_ff[1] <= csr_box;
            CSR_BOX_MAX_Z:  bmax_ff[2] <= csr_box;
            default: ;
         endcase
      end
   end

   logic [WORD_W-2:0] vs;
   assign vs = (vsize_ff == '0) ? (WORD_W-1)'(1) : vsize_ff;

   // ---- item registers ----
   logic                     is_read_ff;
   logic [VIDX_W-1:0]        idx_ff;
   logic signed [WORD_W-1:0] o_ff   [3];
   logic signed [WORD_W-1:0] d_ff   [3];
   logic signed [WORD_W-1:0] inv_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff <= req_func;
         idx_ff     <= req_voxel_index;
         o_ff[0]    <= req_origin_x;
         o_ff[1]    <= req_origin_y;
         o_ff[2]    <= req_origin_z;
         d_ff[0]    <= req_dir_x;
         d_ff[1]    <= req_dir_y;
         d_ff[2]    <= req_dir_z;
         inv_ff[0]  <= req_inv_dir_x;
         inv_ff[1]  <= req_inv_dir_y;
         inv_ff[2]  <= req_inv_dir_z;
      end
   end

   // ---- per-axis selection ----
   logic [1:0]               ax;
   logic signed [WORD_W-1:0] o_a, d_a, inv_a;
   logic signed [BOX_W-1:0]  mn_a, mx_a;
   logic [WORD_W-1:0]        dmag_a, invmag_a;
   logic                     ok_a;

   assign ax       = cmd.axis;
   assign o_a      = o_ff[ax];
   assign d_a      = d_ff[ax];
   assign inv_a    = inv_ff[ax];
   assign mn_a     = bmin_ff[ax];
   assign mx_a     = bmax_ff[ax];
   assign dmag_a   = mag32(d_a);
   assign invmag_a = mag32(inv_a);
   assign ok_a     = d_a != '0;

   // slab bound minus origin
   logic signed [BOX_W:0] sdiff;
   logic [BOX_W-1:0]      sdiff_mag;
   logic                  near_is_max, use_max;

   assign near_is_max = inv_a[WORD_W-1];
   assign use_max     = (cmd.phase == PH_SLAB_N) ? near_is_max : !near_is_max;
   assign sdiff       = (use_max ? (BOX_W+1)'(mx_a) : (BOX_W+1)'(mn_a))
                        - (BOX_W+1)'(o_a);
   assign sdiff_mag   = sdiff[BOX_W] ? BOX_W'(-sdiff) : BOX_W'(sdiff);

   // ---- shared arithmetic units ----
   logic                       is_mul;
   logic [WORD_W-1:0]          mul_a;
   logic [TIME_W-1:0]          mul_b;
   logic                       mul_done;
   logic [TIME_W+WORD_W-1:0]   mul_prod;
   logic [TIME_W-1:0]          div_num;
   logic [WORD_W-1:0]          div_den;
   logic                       div_done;
   logic [TIME_W-1:0]          div_quo;
   logic [WORD_W-1:0]          div_rem;

   logic signed [TIME_W-1:0]   tmin_ff;
   logic signed [REL_W-1:0]    rel_ff;
   logic [TIME_W-1:0]          bnum_ff;
   logic [REL_W-2:0]           rel_mag;

   assign rel_mag = rel_ff[REL_W-1] ? (REL_W-1)'(-rel_ff) : (REL_W-1)'(rel_ff);

   assign is_mul = (cmd.phase == PH_SLAB_N) || (cmd.phase == PH_SLAB_F)
                   || (cmd.phase == PH_ENT_MUL);
   assign mul_a  = (cmd.phase == PH_ENT_MUL) ? dmag_a : invmag_a;
   assign mul_b  = (cmd.phase == PH_ENT_MUL) ? {1'b0, tmin_ff[TIME_W-2:0]}
                                             : TIME_W'(sdiff_mag);

   always_comb begin
      unique case (cmd.phase)
         PH_ENT_DIV: begin
            div_num = TIME_W'(rel_mag);
            div_den = WORD_W'(vs);
         end
         PH_ENT_T: begin
            div_num = bnum_ff;
            div_den = dmag_a;
         end
         default: begin
            div_num = TIME_W'(vs) << FRAC_BITS;
            div_den = dmag_a;
         end
      endcase
   end

   rvc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start && is_mul),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   rvc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start && !is_mul),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // ---- slab capture ----
   logic signed [TIME_W-1:0] tn_ff [3];
   logic signed [TIME_W-1:0] tf_ff [3];
   logic                     slab_miss_ff;
   logic signed [TIME_W-1:0] slab_val, slab_t;
   logic                     slab_neg, outside;

   assign slab_neg = sdiff[BOX_W] ^ inv_a[WORD_W-1];
   assign slab_val = slab_neg ? -$signed(mul_prod[TIME_W-1:0])
                              : $signed(mul_prod[TIME_W-1:0]);
   assign slab_t   = slab_val >>> FRAC_BITS;
   assign outside  = (BOX_W'(o_a) < mn_a) || (BOX_W'(o_a) > mx_a);

   // ---- merge of the three slabs ----
   logic signed [TIME_W-1:0] m1_min, m1_max, m2_min, m2_max;
   logic                     m_miss;

   always_comb begin
      m_miss = slab_miss_ff || (tn_ff[0] > tf_ff[1]) || (tn_ff[1] > tf_ff[0]);
      m1_min = (tn_ff[1] > tn_ff[0]) ? tn_ff[1] : tn_ff[0];
      m1_max = (tf_ff[1] < tf_ff[0]) ? tf_ff[1] : tf_ff[0];
      m_miss = m_miss || (m1_min > tf_ff[2]) || (tn_ff[2] > m1_max);
      m2_min = (tn_ff[2] > m1_min) ? tn_ff[2] : m1_min;
      m2_max = (tf_ff[2] < m1_max) ? tf_ff[2] : m1_max;
      m_miss = m_miss || (m2_min < 0) || (m2_max < 0);
   end

   // ---- entry point: rel = origin +- (|dir| * tmin >> F) - box_min ----
   logic [62:0]              prod_sat, offm;
   logic signed [TIME_W-1:0] offs, rel64, relc;

   assign prod_sat = (mul_prod > (TIME_W+WORD_W)'(PROD_LIM)) ? PROD_LIM : mul_prod[62:0];
   assign offm     = prod_sat >> FRAC_BITS;
   assign offs     = d_a[WORD_W-1] ? -$signed({1'b0, offm}) : $signed({1'b0, offm});
   assign rel64    = TIME_W'(o_a) + offs - TIME_W'(mn_a);
   assign relc     = (rel64 > REL_LIM) ? REL_LIM : ((rel64 < -REL_LIM) ? -REL_LIM : rel64);

   // ---- entry voxel: floor division with boundary rule, then clamp ----
   logic signed [REL_W:0] qpos, qdiv, qadj;
   logic                  r_zero;
   logic [VW-1:0]         qclamp;

   assign qpos   = $signed({1'b0, div_quo[REL_W-1:0]});
   assign r_zero = div_rem == '0;
   assign qdiv   = rel_ff[REL_W-1] ? (r_zero ? -qpos : -qpos - 1'b1) : qpos;
   assign qadj   = (d_a[WORD_W-1] && r_zero) ? qdiv - 1'b1 : qdiv;
   assign qclamp = (qadj < 0) ? '0 : ((qadj > QMAX) ? VOX_MAX : qadj[VW-1:0]);

   // ---- first boundary distance ----
   logic [VW-1:0]           vox_ff [3];
   logic [VW:0]             qb;
   logic [VW+WORD_W-1:0]    bprod;
   logic signed [REL_W+1:0] bdiff;
   logic [REL_W:0]          bmag;

   assign qb    = d_a[WORD_W-1] ? {1'b0, vox_ff[ax]} : {1'b0, vox_ff[ax]} + 1'b1;
   assign bprod = qb * vs;
   assign bdiff = $signed((REL_W+2)'(bprod)) - (REL_W+2)'(rel_ff);
   assign bmag  = bdiff[REL_W+1] ? (REL_W+1)'(-bdiff) : (REL_W+1)'(bdiff);

   // ---- walk ----
   logic [TIME_W-1:0] t_ff  [3];
   logic [TIME_W-1:0] dt_ff [3];
   logic [CW-1:0]     count_ff;
   logic              hit_ff, lim_ff;
   logic [2:0]        ok;
   logic [1:0]        sel;
   logic [CW-1:0]     cnt_n;
   logic [VW-1:0]     vsel;
   logic              sneg, leave, cap, wdone;
   logic [TIME_W:0]   tsum;
   logic [AW-1:0]     cell_addr;

   assign ok[0] = d_ff[0] != '0;
   assign ok[1] = d_ff[1] != '0;
   assign ok[2] = d_ff[2] != '0;

   always_comb begin
      priority if (earlier(ok[0], ok[1], t_ff[0], t_ff[1])
                   && earlier(ok[0], ok[2], t_ff[0], t_ff[2])) begin
         sel = 2'd0;
      end else if (earlier(ok[1], ok[2], t_ff[1], t_ff[2])) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
   end

   assign cnt_n = count_ff + 1'b1;
   assign vsel  = vox_ff[sel];
   assign sneg  = d_ff[sel][WORD_W-1];
   assign leave = sneg ? (vsel == '0) : (vsel == VOX_MAX);
   assign cap   = cnt_n >= STEP_CAP;
   assign wdone = !ok[sel] || leave || cap;
   assign tsum  = {1'b0, t_ff[sel]} + {1'b0, dt_ff[sel]};
   assign cell_addr = AW'(vox_ff[0]) + AW'(vox_ff[1]) * ROW_STEP
                      + AW'(vox_ff[2]) * PLANE_STEP;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slab_miss_ff <= 1'b0;
         hit_ff       <= 1'b0;
         lim_ff       <= 1'b0;
         count_ff     <= '0;
      end
      if (cmd.capture) begin
         unique case (cmd.phase)
            PH_SLAB_N: begin
               tn_ff[ax] <= (inv_a == '0) ? T_MIN : slab_t;
               if (inv_a == '0 && outside) slab_miss_ff <= 1'b1;
            end
            PH_SLAB_F: begin
               tf_ff[ax] <= (inv_a == '0) ? T_MAX : slab_t;
               if (inv_a == '0 && outside) slab_miss_ff <= 1'b1;
            end
            PH_ENT_MUL: rel_ff <= REL_W'(relc);
            PH_ENT_DIV: vox_ff[ax] <= qclamp;
            PH_ENT_T:   t_ff[ax]  <= ok_a ? div_quo : '0;
            PH_ENT_DT:  dt_ff[ax] <= ok_a ? div_quo : '0;
            default: ;
         endcase
      end
      if (cmd.merge) tmin_ff <= m2_min;
      if (cmd.bound) bnum_ff <= TIME_W'(bmag) << FRAC_BITS;
      if (cmd.walk_step) begin
         count_ff <= cnt_n;
         if (wdone) begin
            hit_ff <= 1'b1;
            lim_ff <= ok[sel] && !leave && cap;
         end else begin
            vox_ff[sel] <= sneg ? vsel - 1'b1 : vsel + 1'b1;
            t_ff[sel]   <= tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
         end
      end
   end

   // ---- voxel memory with clearing pass ----
   logic            mem [CELLS];
   logic [AW-1:0]   clr_ff;
   logic            mem_we;
   logic [AW-1:0]   waddr;
   logic [IW-1:0]   idx_ext;
   logic            rd_ff, inr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign mem_we  = cmd.clear_step || cmd.walk_step;
   assign waddr   = cmd.clear_step ? clr_ff : cell_addr;
   assign idx_ext = IW'(idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= !cmd.clear_step;
      if (cmd.rd_issue) begin
         rd_ff  <= mem[idx_ext[AW-1:0]];
         inr_ff <= idx_ext < CELLS_W;
      end
   end

   assign sts.clear_last = cmd.clear_step && (clr_ff == LAST_CELL);
   assign sts.unit_done  = mul_done || div_done;
   assign sts.miss       = m_miss;
   assign sts.walk_done  = wdone;

   assign rsp_hit            = hit_ff;
   assign rsp_carved_count   = 8'(count_ff);
   assign rsp_step_limit_hit = lim_ff;
   assign rsp_voxel_value    = is_read_ff && inr_ff && rd_ff;

endmodule

/* rtl/core/ray_voxel_carving_traversal.sv */
`timescale 1ns / 1ps
// Read beat: the memory read is issued in ST_READ, the response beat follows
// in ST_RESP and the next request is taken once back in ST_IDLE. Carve beat:
// a setup of nine serial multiplies, nine serial divides and glue states,
// then one visited voxel per cycle, up to 3*GRID_SIDE voxels; a miss returns
// from the slab merge. One item at a time. Reset: a clearing pass over all
// GRID_SIDE^3 cells (262144 at the default size) keeps req_ready low; CSR writes only when idle.
// ----------------------------------------------------------------------------
// ray_voxel_carving_traversal - ray carving through a one-bit voxel grid
// Slab test against the box, then a 3D DDA walk marking voxels empty.
// ----------------------------------------------------------------------------
module ray_voxel_carving_traversal
   import rvc_pkg::*;
#(
   parameter int GRID_SIDE = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration writes
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [WORD_W-1:0]         csr_wdata,
   // request beat
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [WORD_W-1:0]  req_origin_x,
   input  logic signed [WORD_W-1:0]  req_origin_y,
   input  logic signed [WORD_W-1:0]  req_origin_z,
   input  logic signed [WORD_W-1:0]  req_dir_x,
   input  logic signed [WORD_W-1:0]  req_dir_y,
   input  logic signed [WORD_W-1:0]  req_dir_z,
   input  logic signed [WORD_W-1:0]  req_inv_dir_x,
   input  logic signed [WORD_W-1:0]  req_inv_dir_y,
   input  logic signed [WORD_W-1:0]  req_inv_dir_z,
   input  logic [VIDX_W-1:0]         req_voxel_index,
   // response beat
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic [7:0]                rsp_carved_count,
   output logic                      rsp_step_limit_hit,
   output logic                      rsp_voxel_value
);

   // The controller walks the phases: clear pass, then per item either a
   // single memory read or the carve sequence (near/far slab times per
   // axis, merge, entry voxel and boundary times per axis, DDA walk).
   // The datapath owns all arithmetic, one shared multiplier and divider,
   // and the voxel memory (one write port, one registered read port).
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Result fields stay in datapath registers, stable while rsp_valid waits.
   rvc_dpath #(
      .GRID_SIDE (GRID_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_func           (req_func),
      .req_origin_x       (req_origin_x),
      .req_origin_y       (req_origin_y),
      .req_origin_z       (req_origin_z),
      .req_dir_x          (req_dir_x),
      .req_dir_y          (req_dir_y),
      .req_dir_z          (req_dir_z),
      .req_inv_dir_x      (req_inv_dir_x),
      .req_inv_dir_y      (req_inv_dir_y),
      .req_inv_dir_z      (req_inv_dir_z),
      .req_voxel_index    (req_voxel_index),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_hit            (rsp_hit),
      .rsp_carved_count   (rsp_carved_count),
      .rsp_step_limit_hit (rsp_step_limit_hit),
      .rsp_voxel_value    (rsp_voxel_value)
   );

endmodule
